[design/twl_pkg.sv]
// ----------------------------------------------------------------------------
// twl_pkg: shared types and constants of the timed wait list
// Entry layout, command, result and status codes, cell control word.
// ----------------------------------------------------------------------------
package twl_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ID_W       = 16;
   localparam int TICK_W     = 16;
   localparam int REL_W      = 5;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      CMD_APPEND  = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_POP     = 3'd2,
      CMD_FIND    = 3'd3,
      CMD_TICK    = 3'd4,
      CMD_RELEASE = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_REPLY    = 2'd0,
      KIND_RELEASED = 2'd1,
      KIND_SUMMARY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   thread_id;
      logic [TICK_W-1:0] wait_ticks;
   } entry_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic      append;
      cnt_type   append_pos;
      logic      step;
      logic      keep;
      cnt_type   tail_pos;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

[design/twl_cell.sv]
// ----------------------------------------------------------------------------
// twl_cell: one slot of the wait list
// Holds one entry; takes the new entry on an append at its position, and on a
// walk step the entry of its right neighbour, or the kept head entry at the tail.
// ----------------------------------------------------------------------------
module twl_cell (
   input  logic                   clock,
   input  twl_pkg::cnt_type       cell_index,
   input  twl_pkg::cell_ctrl_type ctrl,
   input  twl_pkg::entry_type     next_entry,
   output twl_pkg::entry_type     entry
);

   twl_pkg::entry_type entry_ff;
   twl_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.append && (cell_index == ctrl.append_pos)) begin
         entry_in = ctrl.new_entry;
      end else if (ctrl.step) begin
         // the kept head re-enters at the tail, everything else shifts down
         if (ctrl.keep && (cell_index == ctrl.tail_pos)) begin
            entry_in = ctrl.new_entry;
         end else begin
            entry_in = next_entry;
         end
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[design/timed_wait_list.sv]
// Append, pop on an empty list and unused codes go from acceptance to the
// finish state; pop on a non-empty list goes through the walk state. Remove,
// find, tick and release-all walk the list one entry a cycle at the head of the
// cell row, while no release word is held back by a stalled output register.
// One command at a time; the next word is taken once the final result sits in
// the output register.
// Reset empties the list; slot contents stay undefined until written.
// ----------------------------------------------------------------------------
// timed_wait_list: ordered list of waiting threads with timeouts
// Control sequencer and output register around a row of entry cells.
// ----------------------------------------------------------------------------
module timed_wait_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_thread_id,
   input  logic [15:0] req_wait_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_thread_id,
   output logic [15:0] rsp_remaining_time,
   output logic        rsp_by_timeout,
   output logic [4:0]  rsp_released_count,
   output logic        rsp_last
);

   twl_pkg::entry_type     cell_q [twl_pkg::LIST_DEPTH];
   twl_pkg::cell_ctrl_type ctrl;

   twl_pkg::state_type state_ff, state_in;
   twl_pkg::cnt_type   count_ff, count_in;
   twl_pkg::cnt_type   steps_ff, steps_in;
   twl_pkg::cnt_type   rel_cnt_ff, rel_cnt_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [15:0]        id_ff, id_in;
   logic [1:0]         rep_status_ff, rep_status_in;
   logic [15:0]        rep_id_ff, rep_id_in;
   logic [15:0]        rep_time_ff, rep_time_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_id_ff, rsp_id_in;
   logic [15:0]        rsp_time_ff, rsp_time_in;
   logic               rsp_byto_ff, rsp_byto_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   twl_pkg::entry_type head;
   logic [15:0]        dec_ticks;
   logic               out_free;
   logic               out_load;
   logic               drop;
   logic               emit;
   logic               hit;

   // ---------------------------------------------------------------- cell row
   for (genvar i = 0; i < twl_pkg::LIST_DEPTH; i++) begin : g_cell
      twl_pkg::entry_type nbr;
      if (i == twl_pkg::LIST_DEPTH - 1) begin : g_end
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      twl_cell u_cell (
         .clock      (clock),
         .cell_index (twl_pkg::cnt_type'(i)),
         .ctrl       (ctrl),
         .next_entry (nbr),
         .entry      (cell_q[i])
      );
   end

   assign head      = cell_q[0];
   assign dec_ticks = (head.wait_ticks != 16'd0) ? (head.wait_ticks - 16'd1) : 16'd0;
   assign hit       = (head.thread_id == id_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != twl_pkg::ST_IDLE);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      rel_cnt_in    = rel_cnt_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      rep_status_in = rep_status_ff;
      rep_id_in     = rep_id_ff;
      rep_time_in   = rep_time_ff;
      ctrl          = '0;
      out_load      = 1'b0;
      drop          = 1'b0;
      emit          = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_byto_in   = rsp_byto_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         twl_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               id_in         = req_thread_id;
               rep_id_in     = 16'd0;
               rep_time_in   = 16'd0;
               rel_cnt_in    = '0;
               steps_in      = count_ff;
               rep_status_in = twl_pkg::STAT_OK;
               state_in      = (count_ff == '0) ? twl_pkg::ST_FINISH : twl_pkg::ST_WALK;
               unique case (req_command)
                  twl_pkg::CMD_APPEND: begin
                     state_in = twl_pkg::ST_FINISH;
                     if (count_ff == twl_pkg::cnt_type'(twl_pkg::LIST_DEPTH)) begin
                        rep_status_in = twl_pkg::STAT_FULL;
                     end else begin
                        ctrl.append               = 1'b1;
                        ctrl.append_pos           = count_ff;
                        ctrl.new_entry.thread_id  = req_thread_id;
                        ctrl.new_entry.wait_ticks = req_wait_time;
                        count_in                  = count_ff + 1'b1;
                     end
                  end
                  twl_pkg::CMD_REMOVE,
                  twl_pkg::CMD_FIND: begin
                     rep_status_in = twl_pkg::STAT_NOTFOUND;
                  end
                  twl_pkg::CMD_POP: begin
                     steps_in = (count_ff != '0) ? twl_pkg::cnt_type'(1) : '0;
                     if (count_ff == '0) begin
                        rep_status_in = twl_pkg::STAT_NOTFOUND;
                     end
                  end
                  twl_pkg::CMD_TICK,
                  twl_pkg::CMD_RELEASE: begin
                  end
                  default: begin
                     state_in = twl_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         twl_pkg::ST_WALK: begin
            unique case (cmd_ff)
               twl_pkg::CMD_REMOVE:  drop = hit && (rep_status_ff == twl_pkg::STAT_NOTFOUND);
               twl_pkg::CMD_POP:     drop = 1'b1;
               twl_pkg::CMD_TICK: begin
                  drop = (dec_ticks == 16'd0);
                  emit = drop;
               end
               twl_pkg::CMD_RELEASE: begin
                  drop = 1'b1;
                  emit = 1'b1;
               end
               default: begin
               end
            endcase

            // hold the walk while a release word cannot enter the output register
            if (!emit || out_free) begin
               ctrl.step                 = 1'b1;
               ctrl.keep                 = !drop;
               ctrl.tail_pos             = count_ff - 1'b1;
               ctrl.new_entry.thread_id  = head.thread_id;
               ctrl.new_entry.wait_ticks =
                  (cmd_ff == twl_pkg::CMD_TICK) ? dec_ticks : head.wait_ticks;
               if (drop) begin
                  count_in = count_ff - 1'b1;
               end
               steps_in = steps_ff - 1'b1;
               if (steps_ff == twl_pkg::cnt_type'(1)) begin
                  state_in = twl_pkg::ST_FINISH;
               end
               if (emit) begin
                  out_load      = 1'b1;
                  rsp_kind_in   = twl_pkg::KIND_RELEASED;
                  rsp_status_in = twl_pkg::STAT_OK;
                  rsp_id_in     = head.thread_id;
                  rsp_time_in   = (cmd_ff == twl_pkg::CMD_TICK) ? 16'd0 : head.wait_ticks;
                  rsp_byto_in   = (cmd_ff == twl_pkg::CMD_TICK);
                  rsp_count_in  = 5'd0;
                  rsp_last_in   = 1'b0;
                  rel_cnt_in    = rel_cnt_ff + 1'b1;
               end
               if (cmd_ff == twl_pkg::CMD_REMOVE && drop) begin
                  rep_status_in = twl_pkg::STAT_OK;
               end
               if ((cmd_ff == twl_pkg::CMD_POP) || (cmd_ff == twl_pkg::CMD_FIND && hit)) begin
                  rep_status_in = twl_pkg::STAT_OK;
                  rep_id_in     = head.thread_id;
                  rep_time_in   = head.wait_ticks;
               end
            end
         end

         twl_pkg::ST_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = rep_status_ff;
               rsp_id_in     = rep_id_ff;
               rsp_time_in   = rep_time_ff;
               rsp_byto_in   = 1'b0;
               rsp_last_in   = 1'b1;
               if (cmd_ff == twl_pkg::CMD_TICK || cmd_ff == twl_pkg::CMD_RELEASE) begin
                  rsp_kind_in  = twl_pkg::KIND_SUMMARY;
                  rsp_count_in = 5'(rel_cnt_ff);
               end else begin
                  rsp_kind_in  = twl_pkg::KIND_REPLY;
                  rsp_count_in = 5'd0;
               end
               state_in = twl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = twl_pkg::ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twl_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      rel_cnt_ff    <= rel_cnt_in;
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      rep_status_ff <= rep_status_in;
      rep_id_ff     <= rep_id_in;
      rep_time_ff   <= rep_time_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_byto_ff   <= rsp_byto_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_thread_id  = rsp_id_ff;
   assign rsp_remaining_time = rsp_time_ff;
   assign rsp_by_timeout     = rsp_byto_ff;
   assign rsp_released_count = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
